### hw/rtl/nssa_pkg.sv
// Package with the shared types and constants of the nearest surface step assigner.
`timescale 1ns / 1ps
`default_nettype none
package nssa_pkg;

    localparam int COORD_BITS = 20;
    localparam int INDEX_BITS = 6;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int DIST_W     = SQ_W + 2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_STEP   = 2'd2
    } t_op;

    typedef struct packed {
        t_op                           op;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
        logic signed [COORD_BITS-1:0]  pos_z;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] surface_index;
        logic                  assigned;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } t_point;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQUARE,
        S_COMPARE,
        S_FINISH,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic clear;
        logic append;
        logic scan_init;
        logic rd_issue;
        logic diff_en;
        logic sq_en;
        logic take;
        logic advance;
        logic commit;
        logic emit_empty;
    } t_cmd;

    typedef struct packed {
        logic table_empty;
        logic closer;
        logic has_next;
        logic out_free;
    } t_status;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic [DIFF_W-1:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/nssa_ctrl.sv
// Controller state machine that sequences table updates and the forward distance scan.
`timescale 1ns / 1ps
`default_nettype none
module nssa_ctrl import nssa_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_op     i_in_op,
    input  wire t_status i_status,
    output logic         o_in_stall,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    case (i_in_op)
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        OP_APPEND: begin
                            o_cmd.append = 1'b1;
                        end
                        OP_STEP: begin
                            if (i_status.table_empty) begin
                                n_state = S_EMPTY;
                            end else begin
                                o_cmd.scan_init = 1'b1;
                                n_state         = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_state       = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.sq_en = 1'b1;
                n_state     = S_COMPARE;
            end
            S_COMPARE: begin
                if (i_status.closer) begin
                    o_cmd.take = 1'b1;
                    if (i_status.has_next) begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_READ;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_stop_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPARE && !i_status.closer) |=> (r_state == S_FINISH))
        else $error("scan did not stop at a farther entry");

endmodule
`default_nettype wire

### hw/rtl/nssa_datapath.sv
// Datapath with the crossing table memory, the distance unit and the result register.
`timescale 1ns / 1ps
`default_nettype none
module nssa_datapath import nssa_pkg::*; #(
    parameter int MAX_SURFACES = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cmd     i_cmd,
    input  wire t_in_item i_item,
    input  wire logic     i_out_stall,
    output t_status       o_status,
    output logic          o_out_valid,
    output t_out_item     o_out_item
);

    localparam int IDX_W = $clog2(MAX_SURFACES);
    localparam int CNT_W = $clog2(MAX_SURFACES + 1);
    localparam int EXT_W = (IDX_W > INDEX_BITS) ? IDX_W : INDEX_BITS;

    t_point             mem [MAX_SURFACES];
    t_point             r_rd;
    t_point             r_probe;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_start;
    logic [IDX_W-1:0]   r_cur;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_first;
    logic [DIST_W-1:0]  r_best;
    logic [DIFF_W-1:0]  r_dx;
    logic [DIFF_W-1:0]  r_dy;
    logic [DIFF_W-1:0]  r_dz;
    logic [SQ_W-1:0]    r_sx;
    logic [SQ_W-1:0]    r_sy;
    logic [SQ_W-1:0]    r_sz;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic [DIST_W-1:0]  w_dist;
    logic [EXT_W-1:0]   w_best_ext;
    logic               w_full;
    t_point             w_point;

    assign w_point    = '{x: i_item.pos_x, y: i_item.pos_y, z: i_item.pos_z};
    assign w_full     = (r_count == CNT_W'(MAX_SURFACES));
    assign w_dist     = DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
    assign w_best_ext = EXT_W'(r_best_idx);

    assign o_status.table_empty = (r_count == '0);
    assign o_status.closer      = r_first || (w_dist < r_best);
    assign o_status.has_next    = (CNT_W'(r_cur) + CNT_W'(1)) < r_count;
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_start <= '0;
            end else if (i_cmd.append && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_start <= r_best_idx;
            end
            if (i_cmd.commit || i_cmd.emit_empty) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !w_full) begin
            mem[r_count[IDX_W-1:0]] <= w_point;
        end
        if (i_cmd.rd_issue) begin
            r_rd <= mem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_probe <= w_point;
            r_cur   <= (CNT_W'(r_start) >= r_count) ? '0 : r_start;
            r_first <= 1'b1;
        end
        if (i_cmd.diff_en) begin
            r_dx <= abs_diff(r_probe.x, r_rd.x);
            r_dy <= abs_diff(r_probe.y, r_rd.y);
            r_dz <= abs_diff(r_probe.z, r_rd.z);
        end
        if (i_cmd.sq_en) begin
            r_sx <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_sy <= SQ_W'(r_dy) * SQ_W'(r_dy);
            r_sz <= SQ_W'(r_dz) * SQ_W'(r_dz);
        end
        if (i_cmd.take) begin
            r_best     <= w_dist;
            r_best_idx <= r_cur;
            r_first    <= 1'b0;
        end
        if (i_cmd.advance) begin
            r_cur <= r_cur + IDX_W'(1);
        end
        if (i_cmd.commit) begin
            r_out_item.surface_index <= w_best_ext[INDEX_BITS-1:0];
            r_out_item.assigned      <= 1'b1;
        end else if (i_cmd.emit_empty) begin
            r_out_item.surface_index <= '0;
            r_out_item.assigned      <= 1'b0;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SURFACES))
        else $error("crossing count exceeds the table depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(i_cmd.commit || i_cmd.emit_empty))
        else $error("result loaded over a stalled transfer");

    a_take_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> (CNT_W'(r_cur) < r_count))
        else $error("winner taken outside the stored entries");

    a_commit_assigned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_out_valid && r_out_item.assigned))
        else $error("committed step did not produce an assigned result");

endmodule
`default_nettype wire

### hw/rtl/nearest_surface_step_assigner_unit.sv
// Top level of the nearest surface step assigner: controller plus datapath.
// Clear and append items are taken while idle and produce no result.
// A step produces its result once the scan stops and the output is free; the next item is taken
// in the same cycle as the result appears. Each entry passes through the single distance unit
// (table read, coordinate difference, square, sum and compare). An empty table skips the scan.
// Reset zeroes the entry count and search start; table contents stay undefined, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module nearest_surface_step_assigner_unit import nssa_pkg::*; #(
    parameter int MAX_SURFACES = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    t_cmd    w_cmd;
    t_status w_status;

    nssa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_item.op),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    nssa_datapath #(
        .MAX_SURFACES (MAX_SURFACES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_in_item),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
